// ===== src/kps_pkg.sv =====
// ----------------------------------------------------------------------------
// kps_pkg
// Shared types, constants and helpers of the keypad scan and debounce block.
// ----------------------------------------------------------------------------
package kps_pkg;

  localparam int unsigned ROWS_DEF         = 4;
  localparam int unsigned COLUMNS_DEF      = 5;
  localparam int unsigned HISTORY_BITS_DEF = 8;

  localparam int unsigned ROW_FIELD_W = 4;
  localparam int unsigned DRIVE_W     = 5;
  localparam int unsigned CODE_W      = 5;
  localparam int unsigned ROW_IDX_W   = 3;
  localparam int unsigned COL_IDX_W   = 3;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_READ   = 1'b1
  } kps_cmd_e;

  typedef struct packed {
    kps_cmd_e               command;
    logic [ROW_FIELD_W-1:0] row_levels;
  } kps_req_t;

  typedef struct packed {
    logic [DRIVE_W-1:0] column_drive;
    logic               key_valid;
    logic [CODE_W-1:0]  key_code;
  } kps_rsp_t;

  typedef struct packed {
    logic                 hit;
    logic [ROW_IDX_W-1:0] row;
  } kps_hit_t;

  function automatic logic [DRIVE_W-1:0] drive_for(logic [COL_IDX_W-1:0] col,
                                                   int unsigned columns);
    logic [DRIVE_W-1:0] d;
    for (int i = 0; i < DRIVE_W; i++) begin
      d[i] = (i < columns) && (COL_IDX_W'(i) != col);
    end
    return d;
  endfunction

endpackage

// ===== src/matrix_keypad_scan_debounce.sv =====
// ----------------------------------------------------------------------------
// matrix_keypad_scan_debounce
// Keypad scanner with per-key shift-register debounce and new-press reporting.
// ----------------------------------------------------------------------------
// On each request, a sample tick shifts the row levels into the histories
// of the column being driven and advances the column; a read compares
// every debounced level with the last reported one in all column lanes at
// once and returns the highest new press code. The response is held in an
// output register, and a new request is taken in the same cycle the waiting
// response is taken, so the block sustains one request per cycle as long as
// responses are taken. All state resets at once; there is no clearing pass.
// ----------------------------------------------------------------------------
module matrix_keypad_scan_debounce #(
  parameter int unsigned ROWS         = kps_pkg::ROWS_DEF,
  parameter int unsigned COLUMNS      = kps_pkg::COLUMNS_DEF,
  parameter int unsigned HISTORY_BITS = kps_pkg::HISTORY_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  kps_pkg::kps_req_t req_i,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output kps_pkg::kps_rsp_t rsp_o
);
  import kps_pkg::*;

  localparam int unsigned COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  logic              req_fire;
  logic              do_sample, do_read;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROWS-1:0]   row_bits;
  kps_hit_t          hits [COLUMNS];
  logic              key_valid;
  logic [CODE_W-1:0] key_code;
  logic              rsp_valid_q;
  kps_rsp_t          rsp_q;

  assign req_ready_o = !rsp_valid_q || rsp_ready_i;
  assign req_fire    = req_valid_i && req_ready_o;
  assign do_sample   = req_fire && (req_i.command == CMD_SAMPLE);
  assign do_read     = req_fire && (req_i.command == CMD_READ);

  // rows without an input bit read as released
  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      row_bits[r] = (r < ROW_FIELD_W) ? req_i.row_levels[r % ROW_FIELD_W] : 1'b1;
    end
  end

  for (genvar c = 0; c < COLUMNS; c++) begin : g_lane
    kps_lane #(
      .ROWS        (ROWS),
      .HISTORY_BITS(HISTORY_BITS)
    ) u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .sample_i  (do_sample && (col_q == COL_W'(c))),
      .read_i    (do_read),
      .row_bits_i(row_bits),
      .hit_o     (hits[c])
    );
  end

  kps_merge #(
    .ROWS   (ROWS),
    .COLUMNS(COLUMNS)
  ) u_merge (
    .hits_i     (hits),
    .key_valid_o(key_valid),
    .key_code_o (key_code)
  );

  always_comb begin
    col_d = col_q;
    if (do_sample) begin
      col_d = (col_q == COL_W'(COLUMNS - 1)) ? '0 : col_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      col_q <= col_d;
      if (req_fire) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      rsp_q.column_drive <= drive_for(COL_IDX_W'(col_d), COLUMNS);
      rsp_q.key_valid    <= do_read && key_valid;
      rsp_q.key_code     <= (do_read && key_valid) ? key_code : '0;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, col_q} < (COL_W + 1)'(COLUMNS))
    else $error("column index out of range");

  a_sample_no_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_sample |=> rsp_valid_o && !rsp_o.key_valid)
    else $error("sample tick reported a key");

  a_code_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_o.key_valid |-> rsp_o.key_code == '0)
    else $error("key code not zero without a key");

  a_col_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !do_sample |=> $stable(col_q))
    else $error("column moved without a sample tick");

endmodule

// ===== src/kps_lane.sv =====
// ----------------------------------------------------------------------------
// kps_lane
// One keypad column: shift debounce of each row key and new-press detection.
// ----------------------------------------------------------------------------
module kps_lane #(
  parameter int unsigned ROWS         = kps_pkg::ROWS_DEF,
  parameter int unsigned HISTORY_BITS = kps_pkg::HISTORY_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              sample_i,
  input  logic              read_i,
  input  logic [ROWS-1:0]   row_bits_i,
  output kps_pkg::kps_hit_t hit_o
);
  import kps_pkg::*;

  logic [HISTORY_BITS-1:0] hist_q [ROWS];
  logic [HISTORY_BITS-1:0] hist_d [ROWS];
  logic [ROWS-1:0]         deb_q, deb_d;
  logic [ROWS-1:0]         rep_q;
  logic [ROWS-1:0]         fall;

  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      hist_d[r] = {hist_q[r][HISTORY_BITS-2:0], row_bits_i[r]};
      deb_d[r]  = deb_q[r];
      if (&hist_d[r]) begin
        deb_d[r] = 1'b1;
      end else if (hist_d[r] == '0) begin
        deb_d[r] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROWS; r++) begin
        hist_q[r] <= '1;
      end
      deb_q <= '1;
      rep_q <= '1;
    end else begin
      if (sample_i) begin
        hist_q <= hist_d;
        deb_q  <= deb_d;
      end
      if (read_i) begin
        rep_q <= deb_q;
      end
    end
  end

  // highest row that went from released to pressed
  assign fall = rep_q & ~deb_q;

  always_comb begin
    hit_o.hit = read_i && (|fall);
    hit_o.row = '0;
    for (int r = 0; r < ROWS; r++) begin
      if (fall[r]) begin
        hit_o.row = ROW_IDX_W'(r);
      end
    end
  end

endmodule

// ===== src/kps_merge.sv =====
// ----------------------------------------------------------------------------
// kps_merge
// Combines the column lanes into the highest newly pressed key code.
// ----------------------------------------------------------------------------
module kps_merge #(
  parameter int unsigned ROWS    = kps_pkg::ROWS_DEF,
  parameter int unsigned COLUMNS = kps_pkg::COLUMNS_DEF
) (
  input  kps_pkg::kps_hit_t             hits_i [COLUMNS],
  output logic                          key_valid_o,
  output logic [kps_pkg::CODE_W-1:0]    key_code_o
);
  import kps_pkg::*;

  localparam int unsigned SUM_W = $clog2(ROWS * COLUMNS + 1) + 1;

  logic [SUM_W-1:0] code;

  always_comb begin
    key_valid_o = 1'b0;
    code        = '0;
    for (int c = 0; c < COLUMNS; c++) begin
      if (hits_i[c].hit) begin
        key_valid_o = 1'b1;
        code        = SUM_W'(hits_i[c].row) + SUM_W'(ROWS * c);
      end
    end
  end

  assign key_code_o = CODE_W'(code);

endmodule

// ===== test/keypad_scan_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keypad_scan_checker
// Watches the request and response channels of the keypad scanner, keeps its
// own copy of the key histories, debounced and reported levels and scan
// column, and compares every response field by field with the oldest one due.
// ----------------------------------------------------------------------------
module keypad_scan_checker
  import kps_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  input  logic     req_ready_i,
  input  kps_req_t req_i,
  input  logic     rsp_valid_i,
  input  logic     rsp_ready_i,
  input  kps_rsp_t rsp_i,
  output int       fail_count_o,
  output int       pending_o
);

  localparam int unsigned ROWS = ROWS_DEF;
  localparam int unsigned COLS = COLUMNS_DEF;
  localparam int unsigned HIST = HISTORY_BITS_DEF;
  localparam int unsigned KEYS = ROWS * COLS;

  // key index is row + ROWS * column, the same as the reported code
  logic [HIST-1:0] history [KEYS];
  logic [KEYS-1:0] debounced;
  logic [KEYS-1:0] reported;
  int unsigned     scan_col;
  kps_rsp_t        due_reports [$];
  int              mismatches = 0;

  function automatic kps_rsp_t scan_step(kps_req_t r);
    kps_rsp_t    rsp;
    int unsigned key;
    rsp = '0;
    if (scan_col >= COLS) scan_col = 0;
    if (r.command == CMD_SAMPLE) begin
      for (int unsigned k = 0; k < ROWS; k++) begin
        key = scan_col * ROWS + k;
        history[key] = {history[key][HIST-2:0], r.row_levels[k]};
        if (&history[key]) debounced[key] = 1'b1;
        else if (history[key] == '0) debounced[key] = 1'b0;
      end
      scan_col = (scan_col + 1 == COLS) ? 0 : scan_col + 1;
    end else begin
      for (int unsigned k = 0; k < KEYS; k++) begin
        if (debounced[k] != reported[k]) begin
          if (reported[k]) begin
            rsp.key_valid = 1'b1;
            rsp.key_code  = CODE_W'(k);
          end
          reported[k] = debounced[k];
        end
      end
    end
    rsp.column_drive = '1;
    rsp.column_drive[scan_col] = 1'b0;
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    kps_rsp_t want;
    if (!rst_ni) begin
      for (int unsigned k = 0; k < KEYS; k++) history[k] = '1;
      debounced = '1;
      reported  = '1;
      scan_col  = 0;
      due_reports.delete();
    end else begin
      if (rsp_valid_i && rsp_ready_i) begin
        if (due_reports.size() == 0) begin
          $error("response with none due: drive %b valid %0d code %0d",
                 rsp_i.column_drive, rsp_i.key_valid, rsp_i.key_code);
          mismatches++;
        end else begin
          want = due_reports.pop_front();
          if (rsp_i.column_drive !== want.column_drive) begin
            $error("column_drive: expected %b, got %b", want.column_drive,
                   rsp_i.column_drive);
            mismatches++;
          end
          if (rsp_i.key_valid !== want.key_valid) begin
            $error("key_valid: expected %0d, got %0d", want.key_valid, rsp_i.key_valid);
            mismatches++;
          end
          if (rsp_i.key_code !== want.key_code) begin
            $error("key_code: expected %0d, got %0d", want.key_code, rsp_i.key_code);
            mismatches++;
          end
        end
      end
      if (req_valid_i && req_ready_i) due_reports.push_back(scan_step(req_i));
    end
    pending_o    <= due_reports.size();
    fail_count_o <= mismatches;
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives the keypad scanner with sample ticks and reads: a few fixed requests,
// then held key patterns scanned column by column with bounce and noise,
// under three idling mixes, one long response hold-off and one drain pause.
// ----------------------------------------------------------------------------
module tb;
  import kps_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 590;
  localparam int KEY_PERIOD   = 150;
  localparam int NUM_KEYS     = ROWS_DEF * COLUMNS_DEF;

  logic     clk;
  logic     rst_n       = 1'b0;
  logic     req_valid   = 1'b0;
  logic     req_ready;
  kps_req_t req         = '0;
  logic     rsp_valid;
  logic     rsp_ready   = 1'b0;
  kps_rsp_t rsp;
  logic     hold_wanted = 1'b0;
  logic     hold_done   = 1'b0;
  int       fail_count;
  int       outstanding;

  int          tx_idle = 0;
  int          rx_idle = 0;
  logic [NUM_KEYS-1:0] held = '0;
  int unsigned gen_col = 0;

  matrix_keypad_scan_debounce dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .req_i       (req),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_ready),
    .rsp_o       (rsp)
  );

  keypad_scan_checker scan_chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .req_valid_i  (req_valid),
    .req_ready_i  (req_ready),
    .req_i        (req),
    .rsp_valid_i  (rsp_valid),
    .rsp_ready_i  (rsp_ready),
    .rsp_i        (rsp),
    .fail_count_o (fail_count),
    .pending_o    (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // response side, with one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_wanted && !hold_done) begin
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done <= 1'b1;
      end
      rsp_ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  initial begin
    int quiet = 0;
    wait (rst_n);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
      else quiet++;
    end
    $display("tb: done, errors");
    $finish;
  end

  task automatic send_req(input kps_req_t r);
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    if (r.command == CMD_SAMPLE) gen_col = (gen_col + 1) % COLUMNS_DEF;
    if (tx_idle != 0 && $urandom_range(99) < tx_idle) begin
      req_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < tx_idle) @(posedge clk);
    end
  endtask

  // mostly scans of the held keys, some bounce, some reads, some noise
  function automatic kps_req_t make_request();
    kps_req_t r;
    r.command    = CMD_SAMPLE;
    r.row_levels = '1;
    if ($urandom_range(99) < 15) begin
      r.command    = kps_cmd_e'($urandom_range(1));
      r.row_levels = ROW_FIELD_W'($urandom);
    end else if ($urandom_range(99) < 12) begin
      r.command = CMD_READ;
    end else begin
      r.row_levels = ~held[gen_col * ROWS_DEF +: ROWS_DEF];
      if ($urandom_range(99) < 5) r.row_levels ^= ROW_FIELD_W'($urandom);
    end
    return r;
  endfunction

  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_req('{CMD_READ,   4'hf});
    send_req('{CMD_SAMPLE, 4'hf});
    send_req('{CMD_SAMPLE, 4'h0});
    send_req('{CMD_SAMPLE, 4'h5});
    send_req('{CMD_SAMPLE, 4'ha});
    send_req('{CMD_SAMPLE, 4'he});
    send_req('{CMD_SAMPLE, 4'h7});
    send_req('{CMD_READ,   4'h0});
    send_req('{CMD_SAMPLE, 4'hb});
    send_req('{CMD_SAMPLE, 4'hd});
    send_req('{CMD_READ,   4'h5});
    send_req('{CMD_READ,   4'ha});

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle = (ph == 0) ? 9 : (ph == 1) ? 45 : 0;
      rx_idle = (ph == 0) ? 45 : (ph == 1) ? 9 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % KEY_PERIOD == 0) begin
          case ($urandom_range(3))
            0: held = '0;
            1: held = '1;
            default: begin
              for (int k = 0; k < NUM_KEYS; k++) held[k] = ($urandom_range(99) < 20);
            end
          endcase
        end
        if (ph == 0 && n == 100) hold_wanted <= 1'b1;
        send_req(make_request());
      end
      if (ph == 0) drain();
    end

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
